@@ src/dtmm_pkg.sv @@
// Package: shared types and constants for the dual trimmed mean meter.
`timescale 1ns / 1ps
package dtmm_pkg;

  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_VOLTAGE_DIVISOR = 2'd0,
    REG_CURRENT_DIVISOR = 2'd1,
    REG_VOLTAGE_LIMIT   = 2'd2,
    REG_CURRENT_LIMIT   = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] VoltageDivisorReset = 16'd6045;
  localparam logic [15:0] CurrentDivisorReset = 16'd566;
  localparam logic [15:0] VoltageLimitReset   = 16'd380;
  localparam logic [15:0] CurrentLimitReset   = 16'd550;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_MEAN,
    ST_SCALE,
    ST_OUT
  } state_t;

  // Control handed from the sequencer to the ring cells.
  typedef struct packed {
    logic clear;   // reset rank accumulators
  } cell_ctrl_t;

endpackage

@@ src/dtmm_cell.sv @@
// Ring cell: holds one sample and counts how many ring entries rank below it.
`timescale 1ns / 1ps
module dtmm_cell
  import dtmm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned RANK_BITS   = 6,
  parameter int unsigned IDX_BITS    = 6,
  parameter int unsigned MY_INDEX    = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctrl_t             ctrl,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] load_data,
  // Broadcast element and its ring index during the rank sweep.
  input  logic [SAMPLE_BITS-1:0] probe_data,
  input  logic [IDX_BITS-1:0]    probe_idx,
  input  logic                   probe_vld,
  output logic [SAMPLE_BITS-1:0] value,
  output logic [RANK_BITS-1:0]   rank
);

  logic [SAMPLE_BITS-1:0] value_r;
  logic [RANK_BITS-1:0]   rank_r;
  logic                   below;

  // Ties are broken by index so the ranks form a permutation.
  assign below = (probe_data < value_r) ||
                 ((probe_data == value_r) && (probe_idx < IDX_BITS'(MY_INDEX)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else if (load) begin
      value_r <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      rank_r <= '0;
    end else if (probe_vld && below) begin
      rank_r <= rank_r + 1'b1;
    end
  end

  assign value = value_r;
  assign rank  = rank_r;

endmodule

@@ src/dtmm_lane.sv @@
// Lane: one ring of cells, the rank sweep, the trimmed sum and the scaling divide.
`timescale 1ns / 1ps
module dtmm_lane
  import dtmm_pkg::*;
#(
  parameter int unsigned WINDOW      = 30,
  parameter int unsigned TRIM        = 7,
  parameter int unsigned SAMPLE_BITS = 24,
  localparam int unsigned IDX_BITS   = $clog2(WINDOW)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctrl_t             ctrl,
  input  logic                   wr_en,
  input  logic [IDX_BITS-1:0]    wr_slot,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic                   probe_vld,
  input  logic [IDX_BITS-1:0]    probe_idx,
  input  logic                   acc_en,
  input  logic [IDX_BITS-1:0]    acc_idx,
  input  logic                   div_start,
  input  logic [15:0]            divisor,
  input  logic [15:0]            limit,
  output logic                   div_busy,
  output logic [15:0]            result,
  output logic                   warning
);

  localparam int unsigned RANK_BITS  = $clog2(WINDOW);
  localparam int unsigned KEPT       = (2 * TRIM < WINDOW) ? (WINDOW - 2 * TRIM) : 1;
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW + 1);
  localparam int unsigned QB         = SAMPLE_BITS;
  localparam int unsigned CNT_BITS   = $clog2(QB + 1);
  localparam int unsigned DW         = (QB > 16) ? QB : 16;
  localparam int unsigned KEPT_BITS  = $clog2(KEPT);
  localparam int unsigned RSHIFT     = SUM_BITS + KEPT_BITS;
  localparam int unsigned RECIP_BITS = SUM_BITS + 1;
  localparam int unsigned PROD_BITS  = SUM_BITS + RECIP_BITS;
  // Rounded-up reciprocal of the kept count; exact for every sum below 2**SUM_BITS.
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RSHIFT) + 64'(KEPT) - 64'd1) / 64'(KEPT));

  logic [SAMPLE_BITS-1:0] values [WINDOW];
  logic [RANK_BITS-1:0]   ranks  [WINDOW];

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    dtmm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .RANK_BITS  (RANK_BITS),
      .IDX_BITS   (IDX_BITS),
      .MY_INDEX   (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load      (wr_en && (wr_slot == IDX_BITS'(g))),
      .load_data (wr_data),
      .probe_data(values[probe_idx]),
      .probe_idx (probe_idx),
      .probe_vld (probe_vld),
      .value     (values[g]),
      .rank      (ranks[g])
    );
  end

  // Sum the kept entries one per cycle.
  logic [SUM_BITS-1:0] sum_r;
  logic                keep;
  assign keep = (ranks[acc_idx] >= RANK_BITS'(TRIM)) &&
                (32'(ranks[acc_idx]) < WINDOW - TRIM);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum_r <= '0;
    end else if (acc_en && keep) begin
      sum_r <= sum_r + SUM_BITS'(values[acc_idx]);
    end
  end

  // Mean by reciprocal multiplication; zero when nothing is kept.
  logic [PROD_BITS-1:0] prod;
  logic [QB-1:0]        mean;
  assign prod = PROD_BITS'(sum_r) * PROD_BITS'(RECIP);
  assign mean = (2 * TRIM < WINDOW) ? QB'(prod >> RSHIFT) : '0;

  // Restoring division of the mean by the divisor, one bit a cycle.
  logic                busy_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [QB-1:0]       quo_r;
  logic [DW-1:0]       rem_r;
  logic [DW:0]         trial;
  logic [DW:0]         den;
  logic                qbit;
  logic [QB-1:0]       quo_nxt;
  logic [15:0]         result_r;

  assign den     = (DW + 1)'(divisor);
  assign trial   = {rem_r, quo_r[QB-1]};
  assign qbit    = (trial >= den);
  assign quo_nxt = {quo_r[QB-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (div_start) begin
      cnt_r <= CNT_BITS'(QB);
      quo_r <= mean;
      rem_r <= '0;
      if (divisor == 16'd0) begin
        busy_r   <= 1'b0;
        result_r <= 16'hFFFF;
      end else begin
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      rem_r <= DW'(qbit ? (trial - den) : trial);
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
        if (64'(quo_nxt) > 64'hFFFF) begin
          result_r <= 16'hFFFF;
        end else begin
          result_r <= 16'(quo_nxt);
        end
      end
    end
  end

  assign div_busy = busy_r;
  assign result   = result_r;
  assign warning  = result_r > limit;

endmodule

@@ src/dual_trimmed_mean_meter.sv @@
// Top level: dual trimmed mean meter with sequencer and configuration registers.
//
//   Channel | Direction | Ports
//   in      | sink      | in_valid, in_stall, in_voltage_sample, in_current_sample
//   out     | source    | out_valid, out_stall, out_voltage_value, out_current_value,
//           |           | out_voltage_warning, out_current_warning
//   cfg     | sink      | cfg_we, cfg_index, cfg_data
//
// Each transaction steps through acceptance, the rank sweep over the ring,
// the kept sum, loading the divider with the mean, the bit-serial divide, a
// settle step and the result on out. A zero divisor skips the divide. Reset
// clears the rings, the write slot and the registers. The result stays on
// out_* until taken; in_stall holds high from acceptance until the result
// leaves.
`timescale 1ns / 1ps
module dual_trimmed_mean_meter
  import dtmm_pkg::*;
#(
  parameter int unsigned WINDOW      = 30,
  parameter int unsigned TRIM        = 7,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [23:0]            in_voltage_sample,
  input  logic [23:0]            in_current_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            out_voltage_value,
  output logic [15:0]            out_current_value,
  output logic                   out_voltage_warning,
  output logic                   out_current_warning,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int unsigned IDX_BITS = $clog2(WINDOW);

  // Configuration registers.
  logic [15:0] vdiv_r, cdiv_r, vlim_r, clim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdiv_r <= VoltageDivisorReset;
      cdiv_r <= CurrentDivisorReset;
      vlim_r <= VoltageLimitReset;
      clim_r <= CurrentLimitReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VOLTAGE_DIVISOR: vdiv_r <= cfg_data;
        REG_CURRENT_DIVISOR: cdiv_r <= cfg_data;
        REG_VOLTAGE_LIMIT:   vlim_r <= cfg_data;
        REG_CURRENT_LIMIT:   clim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [IDX_BITS-1:0] slot_r, slot_nxt;
  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  logic                in_acc;
  logic                v_busy, c_busy;
  logic                div_start;
  cell_ctrl_t          ctrl;
  logic [15:0]         v_res, c_res;
  logic                v_warn, c_warn;

  assign in_acc = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RANK;
          idx_nxt   = '0;
          slot_nxt  = (32'(slot_r) == WINDOW - 1) ? '0 : slot_r + 1'b1;
        end
      end
      ST_RANK: begin
        idx_nxt = idx_r + 1'b1;
        if (32'(idx_r) == WINDOW - 1) begin
          state_nxt = ST_MEAN;
          idx_nxt   = '0;
        end
      end
      ST_MEAN: begin
        idx_nxt = idx_r + 1'b1;
        if (32'(idx_r) == WINDOW - 1) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (!div_start && !v_busy && !c_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  logic div_pend_r;
  always_comb begin
    ctrl        = '0;
    ctrl.clear  = in_acc;
    in_stall    = (state_r != ST_IDLE);
    out_valid   = (state_r == ST_OUT);
    div_start   = (state_r == ST_SCALE) && div_pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      slot_r     <= '0;
      idx_r      <= '0;
      div_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      slot_r     <= slot_nxt;
      idx_r      <= idx_nxt;
      div_pend_r <= (state_r == ST_MEAN) && (state_nxt == ST_SCALE);
    end
  end

  dtmm_lane #(.WINDOW(WINDOW), .TRIM(TRIM), .SAMPLE_BITS(SAMPLE_BITS)) u_volt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .wr_en    (in_acc),
    .wr_slot  (slot_r),
    .wr_data  (SAMPLE_BITS'(in_voltage_sample)),
    .probe_vld(state_r == ST_RANK),
    .probe_idx(idx_r),
    .acc_en   (state_r == ST_MEAN),
    .acc_idx  (idx_r),
    .div_start(div_start),
    .divisor  (vdiv_r),
    .limit    (vlim_r),
    .div_busy (v_busy),
    .result   (v_res),
    .warning  (v_warn)
  );

  dtmm_lane #(.WINDOW(WINDOW), .TRIM(TRIM), .SAMPLE_BITS(SAMPLE_BITS)) u_curr (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .wr_en    (in_acc),
    .wr_slot  (slot_r),
    .wr_data  (SAMPLE_BITS'(in_current_sample)),
    .probe_vld(state_r == ST_RANK),
    .probe_idx(idx_r),
    .acc_en   (state_r == ST_MEAN),
    .acc_idx  (idx_r),
    .div_start(div_start),
    .divisor  (cdiv_r),
    .limit    (clim_r),
    .div_busy (c_busy),
    .result   (c_res),
    .warning  (c_warn)
  );

  assign out_voltage_value   = v_res;
  assign out_current_value   = c_res;
  assign out_voltage_warning = v_warn;
  assign out_current_warning = c_warn;

`ifndef SYNTHESIS
  // Never take a new sample while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted during output");
  // The write slot stays inside the ring.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_r) < WINDOW) else $error("write slot out of range");
  // Dividers are idle whenever a result is shown.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!v_busy && !c_busy)) else $error("divider busy at output");
`endif

endmodule

@@ test/testbench.sv @@
// Testbench: checks the dual trimmed mean meter against a predictor of its trimmed means.
`timescale 1ns / 1ps
module testbench;
  import dtmm_pkg::*;

  localparam int WINDOW = 30;
  localparam int TRIM = 7;
  localparam int KEPT = WINDOW - 2 * TRIM;
  localparam int LATENCY = 200;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic [15:0] volts;
    logic [15:0] amps;
    logic        volt_warn;
    logic        amp_warn;
  } reading_t;

  typedef struct {
    logic [23:0] v;
    logic [23:0] c;
    bit          known;
    reading_t    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [23:0] in_voltage_sample = '0;
  logic [23:0] in_current_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_voltage_value;
  logic [15:0] out_current_value;
  logic out_voltage_warning;
  logic out_current_warning;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_VOLTAGE_DIVISOR;
  logic [15:0] cfg_data = '0;

  dual_trimmed_mean_meter dut (.*);

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: mirrored rings, slot and registers.
  logic [23:0] volt_ring [WINDOW];
  logic [23:0] amp_ring [WINDOW];
  int          slot_next;
  logic [15:0] volt_div, amp_div, volt_lim, amp_lim;

  reading_t pending_readings[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int cycles = 0;
  bit quiet = 1'b0;       // no idling in the last part of the run
  int in_gap = 0;
  int out_hold = 0;

  // Sort a copy of the ring, drop both tails, average the middle.
  function automatic logic [31:0] trimmed_avg(input logic [23:0] ring [WINDOW]);
    logic [23:0] s [WINDOW];
    logic [23:0] t;
    logic [63:0] acc;
    acc = 0;
    s = ring;
    for (int i = 0; i < WINDOW; i++)
      for (int j = 0; j < WINDOW - 1 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    if (KEPT <= 0) return '0;
    for (int i = TRIM; i < WINDOW - TRIM; i++) acc += s[i];
    return 32'(acc / KEPT);
  endfunction

  function automatic logic [15:0] scaled(input logic [31:0] avg, input logic [15:0] dv);
    logic [31:0] q;
    if (dv == 0) return 16'hFFFF;
    q = avg / dv;
    return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  // Advance the predictor by one sample pair and return the expected reading.
  function automatic reading_t meter_sample(input logic [23:0] v, input logic [23:0] c);
    reading_t r;
    volt_ring[slot_next] = v;
    amp_ring[slot_next] = c;
    slot_next = (slot_next == WINDOW - 1) ? 0 : slot_next + 1;
    r.volts = scaled(trimmed_avg(volt_ring), volt_div);
    r.amps = scaled(trimmed_avg(amp_ring), amp_div);
    r.volt_warn = r.volts > volt_lim;
    r.amp_warn = r.amps > amp_lim;
    return r;
  endfunction

  // Output side: random stall bursts, compare each transaction with the oldest reading.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result v=%0d c=%0d", $time, out_voltage_value,
                 out_current_value);
        errors++;
      end else begin
        reading_t e;
        e = pending_readings.pop_front();
        checked++;
        if (e.volts !== out_voltage_value) begin
          $display("%0t: voltage_value expected %0d actual %0d", $time, e.volts,
                   out_voltage_value);
          errors++;
        end
        if (e.amps !== out_current_value) begin
          $display("%0t: current_value expected %0d actual %0d", $time, e.amps,
                   out_current_value);
          errors++;
        end
        if (e.volt_warn !== out_voltage_warning) begin
          $display("%0t: voltage_warning expected %0b actual %0b", $time, e.volt_warn,
                   out_voltage_warning);
          errors++;
        end
        if (e.amp_warn !== out_current_warning) begin
          $display("%0t: current_warning expected %0b actual %0b", $time, e.amp_warn,
                   out_current_warning);
          errors++;
        end
      end
    end
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_hold <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("** dual_trimmed_mean_meter: FAILED **");
      $finish;
    end
  end

  // Write one register while idle; mirror it into the predictor.
  // The caller drops cfg_we after the last write of a group.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_VOLTAGE_DIVISOR: volt_div = val;
      REG_CURRENT_DIVISOR: amp_div = val;
      REG_VOLTAGE_LIMIT:   volt_lim = val;
      REG_CURRENT_LIMIT:   amp_lim = val;
      default: ;
    endcase
  endtask

  // Present one sample pair, honoring random idle bursts, and hold it until taken.
  task automatic send_pair(input logic [23:0] v, input logic [23:0] c, input bit known,
                           input reading_t res);
    reading_t p;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (in_gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_voltage_sample <= v;
    in_current_sample <= c;
    do @(posedge clk); while (in_stall);
    p = meter_sample(v, c);
    if (known && p !== res)
      $display("%0t: directed row disagrees with predictor", $time);
    pending_readings.push_back(known ? res : p);
    accepted++;
  endtask

  // Let everything drain, then the block's own latency.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_readings.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample(input int mode);
    case (mode)
      0: return 24'($urandom_range(0, 255));
      1: return 24'hFFFFFF - 24'($urandom_range(0, 255));
      2: return 24'($urandom_range(3000000, 6000000));
      default: return 24'($urandom);
    endcase
  endfunction

  stim_row_t rows[$];

  initial begin
    stim_row_t r;
    for (int i = 0; i < WINDOW; i++) begin
      volt_ring[i] = '0;
      amp_ring[i] = '0;
    end
    slot_next = 0;
    volt_div = VoltageDivisorReset;
    amp_div = CurrentDivisorReset;
    volt_lim = VoltageLimitReset;
    amp_lim = CurrentLimitReset;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: zeros from reset, then extremes; one full max sample
    // among zeros is trimmed away so the reading stays zero.
    r = '{v: 24'h0, c: 24'h0, known: 1, res: '{0, 0, 0, 0}};
    rows.push_back(r);
    r = '{v: 24'hFFFFFF, c: 24'hFFFFFF, known: 1, res: '{0, 0, 0, 0}};
    rows.push_back(r);
    for (int i = 0; i < 12; i++) begin
      r = '{v: 24'hFFFFFF, c: 24'hFFFFFF, known: 0, res: '{0, 0, 0, 0}};
      rows.push_back(r);
    end
    for (int i = 0; i < 8; i++) begin
      r = '{v: 24'hAAAAAA ^ (i[0] ? 24'hFFFFFF : 24'h0),
            c: 24'h555555 ^ (i[1] ? 24'hFFFFFF : 24'h0),
            known: 0, res: '{0, 0, 0, 0}};
      rows.push_back(r);
    end
    foreach (rows[k]) send_pair(rows[k].v, rows[k].c, rows[k].known, rows[k].res);
    drain();

    // Random phases through several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_VOLTAGE_DIVISOR, 16'd1); write_reg(REG_CURRENT_DIVISOR, 16'd1);
          write_reg(REG_VOLTAGE_LIMIT, 16'hFFFF); write_reg(REG_CURRENT_LIMIT, 16'd0);
        end
        1: begin
          write_reg(REG_VOLTAGE_DIVISOR, 16'd0); write_reg(REG_CURRENT_DIVISOR, 16'hFFFF);
          write_reg(REG_VOLTAGE_LIMIT, 16'd0); write_reg(REG_CURRENT_LIMIT, 16'hFFFF);
        end
        2: begin
          write_reg(REG_VOLTAGE_DIVISOR, VoltageDivisorReset);
          write_reg(REG_CURRENT_DIVISOR, CurrentDivisorReset);
          write_reg(REG_VOLTAGE_LIMIT, VoltageLimitReset);
          write_reg(REG_CURRENT_LIMIT, CurrentLimitReset);
        end
        default: begin
          write_reg(REG_VOLTAGE_DIVISOR, 16'($urandom_range(0, 65535)));
          write_reg(REG_CURRENT_DIVISOR, 16'($urandom_range(1, 2000)));
          write_reg(REG_VOLTAGE_LIMIT, 16'($urandom_range(0, 65535)));
          write_reg(REG_CURRENT_LIMIT, 16'($urandom_range(0, 3000)));
        end
      endcase
      cfg_we <= 1'b0;
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < 295; n++) begin
        reading_t none;
        none = '0;
        send_pair(rand_sample($urandom_range(0, 3)), rand_sample($urandom_range(0, 3)),
                  0, none);
      end
      drain();
    end

    $display("sent %0d sample pairs, checked %0d readings over 7 register settings",
             accepted, checked);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("** dual_trimmed_mean_meter: PASSED **");
    end else begin
      $display("%0d mismatches, %0d readings never arrived", errors,
               pending_readings.size());
      $display("** dual_trimmed_mean_meter: FAILED **");
    end
    $finish;
  end

endmodule
